// File: rtl/gyro_offset_calibrator_top_assert.svh
// ----------------------------------------------------------------------------
// Gyro offset calibrator assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GYRO_OFFSET_CALIBRATOR_TOP_ASSERT_SVH
`define GYRO_OFFSET_CALIBRATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define GOCAL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GOCAL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/gocal_pkg.sv
// ----------------------------------------------------------------------------
// Gyro offset calibrator package
// Shared constants, codes and types.
// ----------------------------------------------------------------------------
package gocal_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int RATE_WIDTH       = 16;
   localparam int OFFSET_WIDTH     = 16;
   localparam int LIMIT_WIDTH      = 15;
   localparam int SCALE_WIDTH      = 16;
   localparam int COUNT_WIDTH      = 16;
   localparam int NUM_AXES         = 3;
   localparam int CSR_ADDR_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int REQ_DATA_WIDTH   = 48;
   localparam int RSP_DATA_WIDTH   = 56;

   localparam int OFFSET_MAX = 32767;
   localparam int OFFSET_MIN = -32768;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MEAN_SAMPLES = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ERROR_LIMIT  = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_OFFSET_SCALE = 2'd2;

   // register reset values
   localparam logic [COUNT_WIDTH-1:0] MEAN_SAMPLES_RST = 16'd100;
   localparam logic [LIMIT_WIDTH-1:0] ERROR_LIMIT_RST  = 15'd10;
   localparam logic [SCALE_WIDTH-1:0] OFFSET_SCALE_RST = 16'd256;

   // request operation codes
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // per-lane control from the sequencing logic
   typedef struct packed {
      logic sample_en;   // fold a sample into the mean
      logic round_end;   // this sample closes the round
      logic restart;     // clear mean and offset
   } axis_ctrl_type;

endpackage

// File: rtl/gocal_axis.sv
// ----------------------------------------------------------------------------
// Gyro offset calibrator axis lane
// Running mean and offset register for one axis, with round-end correction.
// ----------------------------------------------------------------------------
module gocal_axis
   import gocal_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  axis_ctrl_type                  ctrl,
   input  logic signed [RATE_WIDTH-1:0]   rate,
   input  logic        [LIMIT_WIDTH-1:0]  error_limit,
   input  logic        [SCALE_WIDTH-1:0]  offset_scale,
   output logic signed [OFFSET_WIDTH-1:0] offset_out,
   output logic                           axis_ok
);

   localparam int SUMW = ((SAMPLE_WIDTH > RATE_WIDTH) ? SAMPLE_WIDTH : RATE_WIDTH) + 1;
   localparam int MAGW = ((SAMPLE_WIDTH + 1) > OFFSET_WIDTH) ? (SAMPLE_WIDTH + 1) : OFFSET_WIDTH;
   localparam int PW   = SAMPLE_WIDTH + SCALE_WIDTH + 1;
   localparam int DW   = PW + 1;

   logic signed [SAMPLE_WIDTH-1:0] mean_ff, mean_in;
   logic signed [OFFSET_WIDTH-1:0] offset_ff, offset_in;

   logic signed [SUMW-1:0]         sum_w, sum_adj, half_w;
   logic signed [SAMPLE_WIDTH-1:0] mean_new;
   logic signed [MAGW-1:0]         mean_ext, mag, limit_ext;
   logic signed [PW-1:0]           prod, prod_adj, corr;
   logic signed [DW-1:0]           diff;
   logic signed [OFFSET_WIDTH-1:0] offset_sat;

   always_comb begin
      // mean = (rate + mean) / 2, truncated toward zero, wrapped to lane width
      sum_w    = SUMW'(rate) + SUMW'(mean_ff);
      sum_adj  = sum_w + $signed({{(SUMW-1){1'b0}}, sum_w[SUMW-1]});
      half_w   = sum_adj >>> 1;
      mean_new = half_w[SAMPLE_WIDTH-1:0];

      mean_ext  = MAGW'(mean_new);
      mag       = mean_new[SAMPLE_WIDTH-1] ? -mean_ext : mean_ext;
      limit_ext = $signed({{(MAGW-LIMIT_WIDTH){1'b0}}, error_limit});
      axis_ok   = !(mag > limit_ext);

      // correction = trunc(mean * scale / 256), Q8.8 scale
      prod     = mean_new * $signed({1'b0, offset_scale});
      prod_adj = prod + $signed({{(PW-8){1'b0}}, {8{prod[PW-1]}}});
      corr     = prod_adj >>> 8;

      diff = DW'(offset_ff) - DW'(corr);
      if (diff > DW'(OFFSET_MAX)) begin
         offset_sat = OFFSET_WIDTH'(OFFSET_MAX);
      end else if (diff < DW'(OFFSET_MIN)) begin
         offset_sat = OFFSET_WIDTH'(OFFSET_MIN);
      end else begin
         offset_sat = diff[OFFSET_WIDTH-1:0];
      end

      offset_out = (ctrl.round_end && !axis_ok) ? offset_sat : offset_ff;

      mean_in   = mean_ff;
      offset_in = offset_ff;
      if (ctrl.restart) begin
         mean_in   = '0;
         offset_in = '0;
      end else if (ctrl.sample_en) begin
         if (ctrl.round_end) begin
            mean_in   = '0;
            offset_in = offset_out;
         end else begin
            mean_in = mean_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff   <= '0;
         offset_ff <= '0;
      end else begin
         mean_ff   <= mean_in;
         offset_ff <= offset_in;
      end
   end

endmodule

// File: rtl/gyro_offset_calibrator_top.sv
// ----------------------------------------------------------------------------
// Gyro offset calibrator
// Per-axis running means and offset correction rounds for a 3-axis gyro.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one request per beat. req_tuser selects a gyro sample or a
//   restart; req_tdata carries the three signed rates.
//   rsp channel: one response at the end of every round of mean_samples
//   samples: the three offsets, the in-limit axis mask and a finished flag.
//   csr port: write-only; index 0 mean_samples, 1 error_limit, 2 offset_scale.
//   Write only while the block is idle.
// Timing:
//   A request lands in the input register and is processed in the next
//   cycle unless it is held; the response register loads as a round-ending
//   request is processed, and rsp_tvalid comes straight from it. One request
//   per cycle is sustained while no round-ending request is held; the critical
//   path is add, halve, SAMPLE_WIDTH x 17 multiply (16x17 by default),
//   subtract and saturate in each axis lane.
// Reset / stall:
//   Reset clears offsets, means, sample count, the finished state and loads
//   the register defaults (100, 10, 256). If a response waits in the output
//   register and rsp_tready is low, a round-ending request holds in the input
//   register and req_tready drops; other requests keep flowing.
// ----------------------------------------------------------------------------
`include "gyro_offset_calibrator_top_assert.svh"

module gyro_offset_calibrator_top
   import gocal_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // rate_x, rate_y, rate_z
   input  logic                      req_tuser,   // operation
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // offset_x, offset_y, offset_z,
                                                  // axes_ok, finished, zero pad
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // configuration registers
   logic [COUNT_WIDTH-1:0] mean_samples_ff;
   logic [LIMIT_WIDTH-1:0] error_limit_ff;
   logic [SCALE_WIDTH-1:0] offset_scale_ff;

   // input register
   logic                         in_valid_ff;
   logic                         in_op_ff;
   logic signed [RATE_WIDTH-1:0] in_rate_ff [NUM_AXES];

   // round state
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   done_ff, done_in;

   // output register
   logic                           out_valid_ff;
   logic signed [OFFSET_WIDTH-1:0] out_offset_ff [NUM_AXES];
   logic [NUM_AXES-1:0]            out_ok_ff;
   logic                           out_fin_ff;

   logic                           is_sample, active, round_end, produce;
   logic                           advance, proc, load_rsp, restart_proc;
   logic [COUNT_WIDTH-1:0]         count_inc, target;
   axis_ctrl_type                  lane_ctrl;
   logic signed [OFFSET_WIDTH-1:0] lane_offset [NUM_AXES];
   logic [NUM_AXES-1:0]            lane_ok;

   // ---- sequencing ----
   always_comb begin
      is_sample = (in_op_ff == OP_SAMPLE);
      active    = is_sample && !done_ff;
      count_inc = count_ff + COUNT_WIDTH'(1);
      // zero samples per round acts as one
      target    = (mean_samples_ff == '0) ? COUNT_WIDTH'(1) : mean_samples_ff;
      round_end = active && (count_inc >= target);
      produce   = in_valid_ff && round_end;
      // hold a round-ending request only while the output slot is blocked
      advance   = !produce || !out_valid_ff || rsp_tready;
      proc      = in_valid_ff && advance;
      load_rsp  = proc && round_end;
      restart_proc = proc && !is_sample;

      lane_ctrl.sample_en = proc && active;
      lane_ctrl.round_end = round_end;
      lane_ctrl.restart   = restart_proc;

      count_in = count_ff;
      done_in  = done_ff;
      if (restart_proc) begin
         count_in = '0;
         done_in  = 1'b0;
      end else if (proc && active) begin
         count_in = round_end ? '0 : count_inc;
         if (round_end && (lane_ok == {NUM_AXES{1'b1}})) begin
            done_in = 1'b1;
         end
      end
   end

   assign req_tready = !in_valid_ff || advance;

   // ---- axis lanes ----
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      gocal_axis #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_axis (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (lane_ctrl),
         .rate         (in_rate_ff[a]),
         .error_limit  (error_limit_ff),
         .offset_scale (offset_scale_ff),
         .offset_out   (lane_offset[a]),
         .axis_ok      (lane_ok[a])
      );
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_samples_ff <= MEAN_SAMPLES_RST;
         error_limit_ff  <= ERROR_LIMIT_RST;
         offset_scale_ff <= OFFSET_SCALE_RST;
         in_valid_ff     <= 1'b0;
         count_ff        <= '0;
         done_ff         <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MEAN_SAMPLES: mean_samples_ff <= csr_wdata;
               CSR_ERROR_LIMIT:  error_limit_ff  <= csr_wdata[LIMIT_WIDTH-1:0];
               CSR_OFFSET_SCALE: offset_scale_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         count_ff <= count_in;
         done_ff  <= done_in;

         if (load_rsp) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff <= req_tuser;
         for (int a = 0; a < NUM_AXES; a++) begin
            in_rate_ff[a] <= req_tdata[a*RATE_WIDTH +: RATE_WIDTH];
         end
      end
      if (load_rsp) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            out_offset_ff[a] <= lane_offset[a];
         end
         out_ok_ff  <= lane_ok;
         out_fin_ff <= (lane_ok == {NUM_AXES{1'b1}});
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_fin_ff, out_ok_ff,
                        out_offset_ff[2], out_offset_ff[1], out_offset_ff[0]};

   // ---- assertions ----
   `GOCAL_ASSERT_NXT(a_done_holds, done_ff && !restart_proc, done_ff, "finished state dropped without restart")
   `GOCAL_ASSERT_NXT(a_restart_clears, restart_proc, (count_ff == '0) && !done_ff, "restart did not clear round state")
   `GOCAL_ASSERT_NXT(a_round_clears_count, load_rsp, count_ff == '0, "round end left sample count set")
   `GOCAL_ASSERT_NXT(a_fin_matches_done, load_rsp, rsp_tvalid && (out_fin_ff == done_ff), "finished flag disagrees with state")

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gyro offset calibrator testbench
// Self-checking stream test: a queue-fed request driver, a response monitor,
// and a per-request predictor of the running means and offset rounds.
// Runs directed corner cases, then random phases under several register
// settings and several idle patterns, and one long response back-pressure
// stretch.
// ----------------------------------------------------------------------------
module tb;
   import gocal_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_CYCLES = 8;      // extra wait once the block is idle
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 100;
   localparam int RAND_PHASES  = 12;

   // one pending request; hold_for_drain makes the driver wait for all responses
   typedef struct packed {
      bit                                       hold_for_drain;
      logic                                     op;
      logic [NUM_AXES-1:0][RATE_WIDTH-1:0]      rate;   // x lowest
   } gyro_req_type;

   // response fields in rsp_tdata order, lowest bits last in this list
   typedef struct packed {
      logic                                     finished;
      logic [NUM_AXES-1:0]                      axes_ok;
      logic [NUM_AXES-1:0][OFFSET_WIDTH-1:0]    offset;  // x lowest
   } offset_report_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;   // rate_x, rate_y, rate_z
   logic                      req_tuser  = OP_SAMPLE;   // operation
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;   // offset_x, offset_y, offset_z,
                                           // axes_ok, finished, zero pad
   logic                      csr_we     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr   = CSR_MEAN_SAMPLES;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   gyro_offset_calibrator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // stimulus and expectation stores
   gyro_req_type      pending_reqs[$];
   offset_report_type reports_due[$];

   // idle percentages and back-pressure hold, set by the sequencer
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          recv_hold_left = 0;

   // set by the monitor when the request on the bus was taken
   bit req_taken = 1'b0;

   int fail_count     = 0;
   int reqs_accepted  = 0;
   int reports_seen   = 0;
   int rounds_done    = 0;
   int restarts_seen  = 0;
   int cycle_count    = 0;

   // ------------------------------------------------------------------------
   // Predictor state: our own copy of registers, offsets, means and counter.
   // ------------------------------------------------------------------------
   logic [COUNT_WIDTH-1:0]        cfg_mean_samples = MEAN_SAMPLES_RST;
   logic [LIMIT_WIDTH-1:0]        cfg_error_limit  = ERROR_LIMIT_RST;
   logic [SCALE_WIDTH-1:0]        cfg_offset_scale = OFFSET_SCALE_RST;
   logic signed [OFFSET_WIDTH-1:0] cal_offset[NUM_AXES];
   logic signed [RATE_WIDTH-1:0]   cal_mean[NUM_AXES];
   logic [COUNT_WIDTH-1:0]         round_count;
   bit                             cal_done;

   task automatic clear_calibration();
      for (int a = 0; a < NUM_AXES; a++) begin
         cal_offset[a] = '0;
         cal_mean[a]   = '0;
      end
      round_count = '0;
      cal_done    = 1'b0;
   endtask

   // Fold one accepted request into the predictor; queue a report if the
   // round closes.
   task automatic fold_request(input gyro_req_type r);
      int                          sum;
      int                          mag;
      longint                      corr;
      longint                      next_off;
      int unsigned                 target;
      offset_report_type           rpt;
      if (r.op == OP_RESTART) begin
         clear_calibration();
         restarts_seen++;
         return;
      end
      // finished calibration swallows samples until a restart
      if (cal_done)
         return;
      for (int a = 0; a < NUM_AXES; a++) begin
         sum = int'($signed(r.rate[a])) + int'(cal_mean[a]);
         cal_mean[a] = RATE_WIDTH'(sum / 2);   // int division truncates toward 0
      end
      round_count = round_count + 1'b1;
      target = (cfg_mean_samples == 0) ? 1 : cfg_mean_samples;
      if (round_count < target)
         return;
      rpt = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         mag = (cal_mean[a] < 0) ? -int'(cal_mean[a]) : int'(cal_mean[a]);
         if (mag > int'(cfg_error_limit)) begin
            // Q8.8 scale, product truncated toward zero
            corr = (longint'(cal_mean[a]) * longint'(cfg_offset_scale)) / 256;
            next_off = longint'(cal_offset[a]) - corr;
            if (next_off > OFFSET_MAX)
               next_off = OFFSET_MAX;
            else if (next_off < OFFSET_MIN)
               next_off = OFFSET_MIN;
            cal_offset[a] = OFFSET_WIDTH'(next_off);
         end else begin
            rpt.axes_ok[a] = 1'b1;
         end
         cal_mean[a] = '0;
         rpt.offset[a] = cal_offset[a];
      end
      round_count = '0;
      if (rpt.axes_ok == '1)
         cal_done = 1'b1;
      rpt.finished = cal_done;
      reports_due.push_back(rpt);
   endtask

   initial clear_calibration();

   // ------------------------------------------------------------------------
   // Request driver: changes on the falling edge, fed from pending_reqs.
   // A request stays on the bus until taken; a new one is only picked once
   // the previous one is gone, so tvalid never drops and rises in one step.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      gyro_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (pending_reqs.size() > 0
             && !(pending_reqs[0].hold_for_drain && reports_due.size() > 0)
             && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.rate;
            req_tuser  <= nxt.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response ready: random idling, or a counted hold-off stretch.
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold_left > 0) begin
         rsp_tready <= 1'b0;
         recv_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. Responses are
   // checked before the request of the same edge is folded in; a response
   // never belongs to a request accepted at that same edge.
   // ------------------------------------------------------------------------
   string axis_field[NUM_AXES] = '{"offset_x", "offset_y", "offset_z"};

   always @(posedge clock) begin : watch_channels
      offset_report_type got;
      offset_report_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = offset_report_type'(rsp_tdata[$bits(offset_report_type)-1:0]);
            if (reports_due.size() == 0) begin
               $error("response with nothing expected: tdata=%h", rsp_tdata);
               fail_count++;
            end else begin
               want = reports_due.pop_front();
               reports_seen++;
               if (want.finished)
                  rounds_done++;
               for (int a = 0; a < NUM_AXES; a++)
                  if (got.offset[a] !== want.offset[a]) begin
                     $error("%s mismatch: expected %0d, actual %0d", axis_field[a],
                            $signed(want.offset[a]), $signed(got.offset[a]));
                     fail_count++;
                  end
               if (got.axes_ok !== want.axes_ok) begin
                  $error("axes_ok mismatch: expected %b, actual %b",
                         want.axes_ok, got.axes_ok);
                  fail_count++;
               end
               if (got.finished !== want.finished) begin
                  $error("finished mismatch: expected %b, actual %b",
                         want.finished, got.finished);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fold_request('{hold_for_drain: 1'b0, op: req_tuser, rate: req_tdata});
            reqs_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic gyro_req_type sample_req(input int x, input int y, input int z);
      gyro_req_type r;
      r.hold_for_drain = 1'b0;
      r.op      = OP_SAMPLE;
      r.rate[0] = RATE_WIDTH'(x);
      r.rate[1] = RATE_WIDTH'(y);
      r.rate[2] = RATE_WIDTH'(z);
      return r;
   endfunction

   function automatic gyro_req_type restart_req();
      gyro_req_type r;
      r = sample_req($urandom, $urandom, $urandom);   // rates are don't-care
      r.op = OP_RESTART;
      return r;
   endfunction

   // Mostly readings near the error limit so rounds can pass and finish,
   // some full-range readings, and an occasional restart.
   function automatic gyro_req_type random_req(input int span);
      gyro_req_type r;
      int v[NUM_AXES];
      if ($urandom_range(99) < 5)
         return restart_req();
      for (int a = 0; a < NUM_AXES; a++)
         if ($urandom_range(99) < 60)
            v[a] = int'($urandom_range(2 * span)) - span;
         else
            v[a] = int'($urandom);
      r = sample_req(v[0], v[1], v[2]);
      return r;
   endfunction

   // Block is idle: nothing queued, nothing on the bus, nothing owed.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_tvalid || reports_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back, then drop the enable.
   task automatic set_config(input logic [15:0] samples, input logic [15:0] limit,
                             input logic [15:0] scale);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MEAN_SAMPLES;
      csr_wdata <= samples;
      @(negedge clock);
      csr_addr  <= CSR_ERROR_LIMIT;
      csr_wdata <= limit;
      @(negedge clock);
      csr_addr  <= CSR_OFFSET_SCALE;
      csr_wdata <= scale;
      @(negedge clock);
      csr_we    <= 1'b0;
      cfg_mean_samples = samples;
      cfg_error_limit  = limit[LIMIT_WIDTH-1:0];
      cfg_offset_scale = scale;
   endtask

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   initial begin : sequencer
      logic [15:0]  ph_samples;
      logic [15:0]  ph_limit;
      logic [15:0]  ph_scale;
      int           span;
      gyro_req_type r;

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero round length acts as one, so every sample reports until finished.
      // Largest scale and zero limit drive offsets into both saturation rails.
      set_config(16'd0, 16'd0, 16'hFFFF);
      pending_reqs.push_back(sample_req(32767, -32768, 0));
      pending_reqs.push_back(sample_req(-32768, 32767, -1));
      pending_reqs.push_back(sample_req(32767, 32767, -32768));
      pending_reqs.push_back(sample_req(0, 0, 0));        // all in limit: finished
      pending_reqs.push_back(sample_req(123, -456, 789)); // ignored after finish
      pending_reqs.push_back(restart_req());
      pending_reqs.push_back(sample_req(-1, 1, 32767));
      pending_reqs.push_back(sample_req(-3, 3, -32768));
      pending_reqs.push_back(restart_req());
      pending_reqs.push_back(sample_req(0, 0, 0));
      pending_reqs.push_back(restart_req());
      wait_idle();

      // Widest limit, zero scale: everything passes, offsets never move.
      set_config(16'd2, 16'h7FFF, 16'd0);
      pending_reqs.push_back(sample_req(-32768, -32768, -32768));
      pending_reqs.push_back(sample_req(32767, -32768, 1));
      pending_reqs.push_back(sample_req(5, 6, 7));
      pending_reqs.push_back(restart_req());
      wait_idle();

      // Unit scale, multi-sample rounds with odd sums to exercise truncation.
      set_config(16'd3, 16'd5, 16'd256);
      pending_reqs.push_back(sample_req(7, -7, 3));
      pending_reqs.push_back(sample_req(-9, 9, -1));
      pending_reqs.push_back(sample_req(101, -101, 4));
      pending_reqs.push_back(sample_req(1, -1, 0));
      pending_reqs.push_back(sample_req(2, -2, 0));
      pending_reqs.push_back(sample_req(-3, 3, 1));
      pending_reqs.push_back(restart_req());
      wait_idle();

      // Longest round: a few samples then a restart, no report expected.
      set_config(16'hFFFF, 16'd10, 16'd256);
      for (int i = 0; i < 20; i++)
         pending_reqs.push_back(random_req(40));
      pending_reqs.push_back(restart_req());
      wait_idle();

      // Random phases: receiver-heavy idling, then sender-heavy, then none.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph / 4)
            0:       begin send_idle_pct = 20; recv_idle_pct = 77; end
            1:       begin send_idle_pct = 77; recv_idle_pct = 20; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         ph_samples = (ph % 5 == 3) ? 16'($urandom_range(20, 60))
                                    : 16'($urandom_range(1, 6));
         if (ph == 2)
            ph_limit = 16'd0;
         else if (ph == 5)
            ph_limit = 16'hFFFF;    // top bit is dropped by the 15-bit register
         else
            ph_limit = 16'($urandom_range(0, 40));
         if (ph == 1)
            ph_scale = 16'd0;
         else if (ph == 6)
            ph_scale = 16'hFFFF;
         else
            ph_scale = 16'($urandom);
         set_config(ph_samples, ph_limit, ph_scale);
         span = int'(ph_limit[LIMIT_WIDTH-1:0] > 60 ? 60 : ph_limit[LIMIT_WIDTH-1:0]) + 4;
         pending_reqs.push_back(restart_req());
         for (int i = 0; i < PHASE_ITEMS; i++)
            pending_reqs.push_back(random_req(span));
         wait_idle();
      end

      // Back-pressure: one-sample rounds, receiver held off while the sender
      // keeps offering, so the output and input registers fill and stall.
      // Partway in, the sender waits until every response is back.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(16'd1, 16'd20, 16'd384);
      pending_reqs.push_back(restart_req());
      for (int i = 0; i < 100; i++) begin
         r = random_req(24);
         r.hold_for_drain = (i == 60);
         pending_reqs.push_back(r);
      end
      recv_hold_left = 300;
      wait_idle();

      $display("covered %0d requests (%0d restarts), %0d responses checked",
               reqs_accepted, restarts_seen, reports_seen);
      $display("%0d rounds reached finished; register extremes, saturation and stalls hit",
               rounds_done);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
